// ----- hdl/matrix4_vector_transform_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Matrix-vector transform unit: assertion macros
// Concurrent assertion wrappers; they collapse to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_VECTOR_TRANSFORM_UNIT_DEFINES_SVH
`define MATRIX4_VECTOR_TRANSFORM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define MVT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("mvt assertion failed");
// Check that expr never holds outside reset.
`define MVT_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("mvt forbidden condition seen");
`else
`define MVT_ASSERT(label, clk, rstn, prop)
`define MVT_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

// ----- hdl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector transform package
// Item kinds, field layout of the stream words and saturation limits.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 4;
    localparam int FUNC_W    = 2;

    // s_tdata layout, lowest bit up
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + INDEX_W;
    localparam int VEC_LSB   = VAL_LSB + DATA_W;
    localparam int S_RAW_W   = VEC_LSB + 4 * DATA_W;
    localparam int S_TDATA_W = ((S_RAW_W + 7) / 8) * 8;

    // m_tdata layout: out_x, out_y, out_z, out_w
    localparam int OUT_COMP  = 4;
    localparam int M_TDATA_W = OUT_COMP * DATA_W;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_WR_A   = 2'd0;
    localparam func_t FUNC_WR_B   = 2'd1;
    localparam func_t FUNC_MAT_MUL = 2'd2;
    localparam func_t FUNC_XFORM  = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

// ----- hdl/matrix4_vector_transform_unit.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector transform unit
// Element writes go straight to RAM. Transform over R = min(DIM,4) rows and
// terms, and matrix product A=A*B, both run on the
// single shared multiply-accumulate fed from one RAM read port per cycle.
// Takes no new item until the last one is done; s_tready is low while busy.
// Reset: synchronous active-low; both matrices read as zero until written.
// ----------------------------------------------------------------------------
`include "matrix4_vector_transform_unit_defines.svh"

module matrix4_vector_transform_unit #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // elem_index[3:0], elem_value[35:4], vec_x[67:36], vec_y[99:68],
    // vec_z[131:100], vec_w[163:132], zero pad above
    input  logic [mvt_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [mvt_pkg::FUNC_W-1:0]    s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [mvt_pkg::M_TDATA_W-1:0] m_tdata,
    // saturated[0]
    output logic                          m_tuser
);

    import mvt_pkg::*;

    localparam int CELLS  = DIM * DIM;
    localparam int AW     = $clog2(CELLS);
    localparam int IW     = $clog2(DIM);
    localparam int VEC_N  = (DIM < 4) ? DIM : 4;     // rows and vector terms used
    localparam int VW     = $clog2(VEC_N);
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(DIM);     // room for DIM full products
    localparam int TOP_LO = FRAC_BITS + DATA_W - 1;   // sign bit of the shifted sum
    localparam int HI_W   = ACC_W - TOP_LO;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VEC   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    func_t                     in_func;
    logic [INDEX_W-1:0]        in_index;
    logic [DATA_W-1:0]         in_value;
    logic                      in_accept;
    logic                      in_index_ok;

    assign in_func     = s_tuser;
    assign in_index    = s_tdata[IDX_LSB +: INDEX_W];
    assign in_value    = s_tdata[VAL_LSB +: DATA_W];
    assign in_accept   = s_tvalid && s_tready;
    assign in_index_ok = int'(in_index) < CELLS;

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    logic [2:0]              state_reg, state_next;
    logic [IW-1:0]           r_reg, r_next;
    logic [IW-1:0]           c_reg, c_next;
    logic [IW-1:0]           e_reg, e_next;
    logic                    prod_mode_reg;     // 1: matrix product, 0: transform

    logic signed [DATA_W-1:0] vec_reg    [VEC_N];
    logic signed [DATA_W-1:0] rowbuf_reg [DIM];   // old row of A during a product
    logic [DATA_W-1:0]        res_reg    [VEC_N];
    logic                     sat_reg;

    logic [CELLS-1:0]         a_valid_reg;
    logic [CELLS-1:0]         b_valid_reg;

    // pipeline: stage 1 = RAM read data, stage 2 = product, stage 3 = sum
    logic                     vld1_reg, load1_reg, first1_reg, last1_reg, srcb1_reg, rv1_reg;
    logic [AW-1:0]            dest1_reg;
    logic signed [DATA_W-1:0] op2_1_reg;
    logic                     vld2_reg, first2_reg, last2_reg;
    logic [AW-1:0]            dest2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     done3_reg;
    logic [AW-1:0]            dest3_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tuser_reg;
    logic [M_TDATA_W-1:0]     out_word;

    // ------------------------------------------------------------------
    // RAMs for A and B
    // ------------------------------------------------------------------
    logic                     a_we, b_we;
    logic [AW-1:0]            a_waddr;
    logic [DATA_W-1:0]        a_wdata;
    logic [AW-1:0]            a_raddr, b_raddr;
    logic [DATA_W-1:0]        a_rdata, b_rdata;

    mvt_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_a (
        .clk     (aclk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (a_wdata),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    mvt_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_b (
        .clk     (aclk),
        .wr_en   (b_we),
        .wr_addr (AW'(in_index)),
        .wr_data (in_value),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    // ------------------------------------------------------------------
    // Issue stage: addresses and operand tags for the shared MAC
    // ------------------------------------------------------------------
    logic                     issue;
    logic                     is_load, is_first, is_last, is_srcb;
    logic [AW-1:0]            is_dest;
    logic signed [DATA_W-1:0] is_op2;
    logic [AW-1:0]            addr_rc, addr_re, addr_ec;

    assign addr_rc = AW'(int'(r_reg) + int'(c_reg) * DIM);
    assign addr_re = AW'(int'(r_reg) + int'(e_reg) * DIM);
    assign addr_ec = AW'(int'(e_reg) + int'(c_reg) * DIM);

    assign a_raddr = (state_reg == S_LOAD) ? addr_re : addr_rc;
    assign b_raddr = addr_ec;

    always_comb begin
        issue    = 1'b0;
        is_load  = 1'b0;
        is_first = 1'b0;
        is_last  = 1'b0;
        is_srcb  = 1'b0;
        is_dest  = '0;
        is_op2   = '0;
        unique case (state_reg)
            S_VEC: begin
                issue    = 1'b1;
                is_first = (c_reg == '0);
                is_last  = (c_reg == IW'(VEC_N - 1));
                is_dest  = AW'(r_reg);
                is_op2   = vec_reg[c_reg[VW-1:0]];
            end
            S_LOAD: begin
                issue    = 1'b1;
                is_load  = 1'b1;
                is_dest  = AW'(e_reg);
            end
            S_MAC: begin
                issue    = 1'b1;
                is_srcb  = 1'b1;
                is_first = (e_reg == '0);
                is_last  = (e_reg == IW'(DIM - 1));
                is_dest  = addr_rc;
                is_op2   = rowbuf_reg[e_reg];
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic pipe_empty;
    logic out_free;

    assign pipe_empty = !vld1_reg && !vld2_reg && !done3_reg;
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        unique case (state_reg)
            S_IDLE: begin
                r_next = '0;
                c_next = '0;
                e_next = '0;
                if (in_accept && in_func == FUNC_MAT_MUL) begin
                    state_next = S_LOAD;
                end else if (in_accept && in_func == FUNC_XFORM) begin
                    state_next = S_VEC;
                end
            end
            S_VEC: begin
                // step along the row, then to the next row
                if (c_reg == IW'(VEC_N - 1)) begin
                    c_next = '0;
                    if (r_reg == IW'(VEC_N - 1)) begin
                        state_next = S_DRAIN;
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_LOAD: begin
                if (e_reg == IW'(DIM - 1)) begin
                    e_next     = '0;
                    c_next     = '0;
                    state_next = S_MAC;
                end else begin
                    e_next = e_reg + 1'b1;
                end
            end
            S_MAC: begin
                if (e_reg == IW'(DIM - 1)) begin
                    e_next = '0;
                    if (c_reg == IW'(DIM - 1)) begin
                        c_next = '0;
                        if (r_reg == IW'(DIM - 1)) begin
                            state_next = S_DRAIN;
                        end else begin
                            r_next     = r_reg + 1'b1;
                            state_next = S_LOAD;
                        end
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end else begin
                    e_next = e_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (pipe_empty) begin
                    state_next = prod_mode_reg ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Stage 1: mask never-written entries, multiply or fill the row buffer
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] data1;
    logic                     rd_valid;

    assign rd_valid = is_srcb ? b_valid_reg[b_raddr] : a_valid_reg[a_raddr];
    assign data1    = rv1_reg ? (srcb1_reg ? b_rdata : a_rdata) : '0;

    // ------------------------------------------------------------------
    // Stage 2: accumulate
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = (first2_reg ? '0 : acc_reg)
                    + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // ------------------------------------------------------------------
    // Stage 3: shift by FRAC_BITS and saturate to 32 bits
    // ------------------------------------------------------------------
    logic [HI_W-1:0]   fin_hi;
    logic              fin_sat;
    logic [DATA_W-1:0] fin_val;

    assign fin_hi  = acc_reg[ACC_W-1:TOP_LO];
    assign fin_sat = !(&fin_hi) && (|fin_hi);
    assign fin_val = fin_sat ? (acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX)
                             : acc_reg[TOP_LO:FRAC_BITS];

    // A write port: element writes when idle, product entries when busy
    always_comb begin
        a_we    = 1'b0;
        a_waddr = AW'(in_index);
        a_wdata = in_value;
        if (done3_reg && prod_mode_reg) begin
            a_we    = 1'b1;
            a_waddr = dest3_reg;
            a_wdata = fin_val;
        end else if (in_accept && in_func == FUNC_WR_A && in_index_ok) begin
            a_we    = 1'b1;
        end
    end

    assign b_we = in_accept && in_func == FUNC_WR_B && in_index_ok;

    // Pack the collected rows; rows that do not exist stay zero
    always_comb begin
        out_word = '0;
        for (int k = 0; k < VEC_N; k++) begin
            out_word[k * DATA_W +: DATA_W] = res_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            r_reg        <= '0;
            c_reg        <= '0;
            e_reg        <= '0;
            a_valid_reg  <= '0;
            b_valid_reg  <= '0;
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            done3_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            e_reg     <= e_next;
            if (a_we) begin
                a_valid_reg[a_waddr] <= 1'b1;
            end
            if (b_we) begin
                b_valid_reg[AW'(in_index)] <= 1'b1;
            end
            vld1_reg  <= issue;
            vld2_reg  <= vld1_reg && !load1_reg;
            done3_reg <= vld2_reg && last2_reg;
            // hold the result until taken, then drop valid
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            prod_mode_reg <= (in_func == FUNC_MAT_MUL);
        end
        if (in_accept && in_func == FUNC_XFORM) begin
            for (int k = 0; k < VEC_N; k++) begin
                vec_reg[k] <= s_tdata[VEC_LSB + k * DATA_W +: DATA_W];
            end
        end

        // stage 1 tags
        load1_reg  <= is_load;
        first1_reg <= is_first;
        last1_reg  <= is_last;
        srcb1_reg  <= is_srcb;
        rv1_reg    <= rd_valid;
        dest1_reg  <= is_dest;
        op2_1_reg  <= is_op2;

        // stage 2
        if (vld1_reg && load1_reg) begin
            rowbuf_reg[dest1_reg[IW-1:0]] <= data1;
        end
        prod_reg   <= data1 * op2_1_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        dest2_reg  <= dest1_reg;

        // stage 3
        if (vld2_reg) begin
            acc_reg <= acc_next;
        end
        dest3_reg <= dest2_reg;

        // transform results collect here until the output register frees
        if (in_accept && in_func == FUNC_XFORM) begin
            sat_reg <= 1'b0;
        end else if (done3_reg && !prod_mode_reg) begin
            res_reg[dest3_reg[VW-1:0]] <= fin_val;
            sat_reg <= sat_reg | fin_sat;
        end

        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= out_word;
            m_tuser_reg <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MVT_ASSERT(a_ready_pipe_empty, aclk, aresetn, s_tready |-> pipe_empty)
    `MVT_ASSERT(a_out_pipe_empty, aclk, aresetn, (state_reg == S_OUT) |-> pipe_empty)
    `MVT_ASSERT(a_valid_from_out, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
    `MVT_ASSERT_NEVER(a_done_when_idle, aclk, aresetn, done3_reg && (state_reg == S_IDLE || state_reg == S_OUT))

endmodule

// ----- hdl/mvt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- bench/matrix4_vector_transform_unit_test.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector transform unit testbench
// Drives element writes, matrix products and vector transforms into the
// stream input. Produces every expected result in a predictor of its own and
// checks each transform result field by field, in order. Both sides idle at
// random. The receiver holds off once for a long stretch so that back
// pressure reaches the input.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int DIM             = 4;
    localparam int FRAC_BITS       = 16;
    localparam int CELLS           = DIM * DIM;
    localparam int ACC_W           = 80;     // four 64-bit products plus headroom
    localparam int RANDOM_ITEMS    = 1950;
    localparam int HOLD_OFF_AFTER  = 500;    // accepted transactions before the long stall
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 128;    // longer than a matrix product runs

    localparam logic signed [ACC_W-1:0] ACC_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -80'sh8000_0000;
    localparam logic [DATA_W-1:0]       Q_ONE     = 32'h0001_0000;
    localparam logic [DATA_W-1:0]       Q_NEG_ONE = 32'hFFFF_0000;

    // One input item; vec[0] is x, vec[3] is w.
    typedef struct packed {
        func_t                    fn;
        logic [INDEX_W-1:0]       idx;
        logic [DATA_W-1:0]        val;
        logic [3:0][DATA_W-1:0]   vec;
    } matrix_cmd_t;

    // One transform result.
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] w;
        logic              sat;
    } xform_result_t;

    // Keeps its own copy of both matrices and the transforms still owed.
    class transform_scoreboard;
        logic signed [DATA_W-1:0] mat_a [CELLS];
        logic signed [DATA_W-1:0] mat_b [CELLS];
        xform_result_t            predicted_xforms [$];
        int                       mismatches;

        function new();
            foreach (mat_a[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            mismatches = 0;
        endfunction

        // Drop the fraction bits arithmetically, then clamp to 32 bits.
        function logic [DATA_W-1:0] shift_saturate(logic signed [ACC_W-1:0] acc,
                                                   inout logic hit);
            logic signed [ACC_W-1:0] shifted;
            shifted = acc >>> FRAC_BITS;
            if (shifted > ACC_MAX) begin
                hit = 1'b1;
                return SAT_MAX;
            end
            if (shifted < ACC_MIN) begin
                hit = 1'b1;
                return SAT_MIN;
            end
            return shifted[DATA_W-1:0];
        endfunction

        function void apply_cmd(matrix_cmd_t cmd);
            logic signed [DATA_W-1:0] product [CELLS];
            logic signed [ACC_W-1:0]  acc;
            logic signed [DATA_W-1:0] comp;
            logic [3:0][DATA_W-1:0]   rows;
            logic                     hit;
            xform_result_t            res;
            case (cmd.fn)
                FUNC_WR_A: begin
                    if (cmd.idx < CELLS) mat_a[cmd.idx] = cmd.val;
                end
                FUNC_WR_B: begin
                    if (cmd.idx < CELLS) mat_b[cmd.idx] = cmd.val;
                end
                FUNC_MAT_MUL: begin
                    // Build the full product before A changes; the flag is dropped.
                    for (int r = 0; r < DIM; r++) begin
                        for (int c = 0; c < DIM; c++) begin
                            acc = '0;
                            for (int e = 0; e < DIM; e++)
                                acc = acc + ACC_W'(mat_a[r + e * DIM]) *
                                            ACC_W'(mat_b[e + c * DIM]);
                            hit = 1'b0;
                            product[r + c * DIM] = shift_saturate(acc, hit);
                        end
                    end
                    mat_a = product;
                end
                FUNC_XFORM: begin
                    hit  = 1'b0;
                    rows = '0;
                    for (int r = 0; r < 4 && r < DIM; r++) begin
                        acc = '0;
                        for (int c = 0; c < DIM; c++) begin
                            comp = (c < 4) ? cmd.vec[c] : '0;
                            acc  = acc + ACC_W'(mat_a[r + c * DIM]) * ACC_W'(comp);
                        end
                        rows[r] = shift_saturate(acc, hit);
                    end
                    res.x   = rows[0];
                    res.y   = rows[1];
                    res.z   = rows[2];
                    res.w   = rows[3];
                    res.sat = hit;
                    predicted_xforms.push_back(res);
                end
            endcase
        endfunction

        function int pending();
            return predicted_xforms.size();
        endfunction

        function void compare_output(logic [M_TDATA_W-1:0] data, logic sat_flag);
            xform_result_t got;
            xform_result_t want;
            got.x   = data[0 * DATA_W +: DATA_W];
            got.y   = data[1 * DATA_W +: DATA_W];
            got.z   = data[2 * DATA_W +: DATA_W];
            got.w   = data[3 * DATA_W +: DATA_W];
            got.sat = sat_flag;
            if (predicted_xforms.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: result with no transform pending: %h %h %h %h sat %b",
                             got.x, got.y, got.z, got.w, got.sat);
                mismatches++;
                return;
            end
            want = predicted_xforms.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.w !== want.w || got.sat !== want.sat) begin
                if (mismatches < 10)
                    $display("ERROR: mismatch exp %h %h %h %h sat %b got %h %h %h %h sat %b",
                             want.x, want.y, want.z, want.w, want.sat,
                             got.x, got.y, got.z, got.w, got.sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    transform_scoreboard transform_board;
    int                  items_accepted = 0;

    matrix4_vector_transform_unit #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Check every result transaction against the oldest predicted transform.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            transform_board.compare_output(m_tdata, m_tuser);
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("matrix4_vector_transform_unit_test NOT OK");
        $finish;
    end

    // Mostly values of a few units, some full-range words and some extremes.
    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    3:       return Q_ONE;
                    default: return Q_NEG_ONE;
                endcase
            end
            1, 2:    return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic matrix_cmd_t make_cmd(func_t fn, logic [INDEX_W-1:0] idx,
                                             logic [DATA_W-1:0] val, x, y, z, w);
        matrix_cmd_t cmd;
        cmd.fn     = fn;
        cmd.idx    = idx;
        cmd.val    = val;
        cmd.vec[0] = x;
        cmd.vec[1] = y;
        cmd.vec[2] = z;
        cmd.vec[3] = w;
        return cmd;
    endfunction

    // Unused fields carry random content too; the block must ignore them.
    function automatic matrix_cmd_t rand_cmd();
        int    pick;
        func_t fn;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            fn = FUNC_WR_A;
        else if (pick < 50)
            fn = FUNC_WR_B;
        else if (pick < 56)
            fn = FUNC_MAT_MUL;
        else
            fn = FUNC_XFORM;
        return make_cmd(fn, INDEX_W'($urandom_range(0, 15)), rand_q16(),
                        rand_q16(), rand_q16(), rand_q16(), rand_q16());
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_cmd(matrix_cmd_t cmd);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[IDX_LSB +: INDEX_W] = cmd.idx;
        word[VAL_LSB +: DATA_W]  = cmd.val;
        for (int k = 0; k < 4; k++)
            word[VEC_LSB + k * DATA_W +: DATA_W] = cmd.vec[k];
        s_tdata  <= word;
        s_tuser  <= cmd.fn;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        transform_board.apply_cmd(cmd);
        items_accepted++;
    endtask

    // Receiver: change stall pattern after each random span; stall once
    // for a long stretch mid-run while the sender keeps offering.
    initial begin
        int   mode;
        int   span;
        logic long_hold_done;
        long_hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 256);
            for (int k = 0; k < span; k++) begin
                if (!long_hold_done && items_accepted >= HOLD_OFF_AFTER) begin
                    long_hold_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= k[2];
                endcase
                @(posedge aclk);
            end
        end
    end

    // Sender: reset, directed transactions, then random bursts.
    initial begin
        matrix_cmd_t directed_q [$];
        int          burst_left;
        int          gap;
        transform_board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Transform through the all-zero matrix after reset.
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
        // Load identity into A and pass extremes through it.
        for (int d = 0; d < 4; d++)
            directed_q.push_back(make_cmd(FUNC_WR_A, INDEX_W'(d * 5), Q_ONE, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, SAT_MAX, SAT_MIN, Q_ONE, Q_NEG_ONE));
        // Saturate high, then low, on row x.
        directed_q.push_back(make_cmd(FUNC_WR_A, '0, SAT_MAX, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, SAT_MAX, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, SAT_MIN, '0, '0, '0));
        // Most negative times most negative on the last element.
        directed_q.push_back(make_cmd(FUNC_WR_A, 4'd15, SAT_MIN, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, '0, '0, '0, SAT_MIN));
        // B as identity plus a translation of 3.5 in x.
        for (int d = 0; d < 4; d++)
            directed_q.push_back(make_cmd(FUNC_WR_B, INDEX_W'(d * 5), Q_ONE, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_WR_B, 4'd12, 32'h0003_8000, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_MAT_MUL, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE));
        // Products whose entries clamp on their own.
        directed_q.push_back(make_cmd(FUNC_WR_B, '0, SAT_MAX, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_MAT_MUL, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, Q_NEG_ONE, SAT_MAX, '0, Q_ONE));
        directed_q.push_back(make_cmd(FUNC_WR_B, 4'd15, SAT_MIN, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_MAT_MUL, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(make_cmd(FUNC_XFORM, '0, '0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        foreach (directed_q[i])
            send_cmd(directed_q[i]);

        // Random bursts; some bursts run straight into the next one.
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_cmd(rand_cmd());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give any stray result time to show up.
        while (transform_board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (transform_board.mismatches == 0)
            $display("matrix4_vector_transform_unit_test OK");
        else
            $display("matrix4_vector_transform_unit_test NOT OK");
        $finish;
    end

endmodule
